// File: hdl/btmf_pkg.sv
// Package for the battery trimmed mean filter.
// Sample and voltage widths, the default window length and the fixed-point
// constant for the millivolt scaling. No dependencies.
`default_nettype none

package btmf_pkg;

  localparam int unsigned SAMPLE_W       = 12;
  localparam int unsigned MV_W           = 14;
  localparam int unsigned WINDOW_DEFAULT = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MV_W-1:0]     mv_t;

  localparam sample_t SAMPLE_MAX = '1;

  // Millivolts are floor(mean * 7480 / 2457).  The ratio is applied as a
  // multiply by ceil(7480 * 2^24 / 2457) and a shift by 24, which is exact
  // for every 12-bit mean.
  localparam longint unsigned MV_NUM    = 7480;
  localparam longint unsigned MV_DEN    = 2457;
  localparam int unsigned     MV_SHIFT  = 24;
  localparam int unsigned     MV_MULT_W = 26;
  localparam logic [MV_MULT_W-1:0] MV_MULT =
    MV_MULT_W'((MV_NUM * (64'd1 << MV_SHIFT) + MV_DEN - 64'd1) / MV_DEN);

endpackage

`default_nettype wire

// File: hdl/btmf_ifs.sv
// Ready/valid channel interfaces for the battery trimmed mean filter.
// Depends on btmf_pkg for the payload types.
`default_nettype none

interface btmf_in_if;
  import btmf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface btmf_out_if;
  import btmf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t mean_sample;
  mv_t     battery_millivolts;

  modport source (output valid, output mean_sample, output battery_millivolts, input ready);
  modport sink   (input valid, input mean_sample, input battery_millivolts, output ready);
endinterface

`default_nettype wire

// File: hdl/btmf_window.sv
// Input register and window accumulator: running sum, minimum, maximum and
// count. Emits the raw first sample or the trimmed window sum. Uses btmf_pkg.
`default_nettype none

module btmf_window
  import btmf_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire sample_t                                in_sample,
  output logic                                        o_valid,
  input  wire logic                                   o_ready,
  output logic                                        o_raw,
  output logic [SAMPLE_W+$clog2(WINDOW)-1:0]          o_value
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW);

  logic             smp_valid_r;
  sample_t          smp_r;
  logic             primed_r, primed_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  sample_t          min_r, min_nxt;
  sample_t          max_r, max_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic             raw_r;
  logic [SUM_W-1:0] value_r;

  logic             move;
  logic             emit;
  logic             raw_now;
  logic [SUM_W-1:0] sum_add;
  logic [SUM_W-1:0] trimmed;
  sample_t          min_new;
  sample_t          max_new;
  logic             last;

  // The result register frees up when it is empty or its beat is taken.
  assign move     = smp_valid_r && (!res_valid_r || o_ready);
  assign in_ready = !smp_valid_r || !res_valid_r || o_ready;

  always_comb begin
    sum_add = sum_r + SUM_W'(smp_r);
    min_new = (smp_r < min_r) ? smp_r : min_r;
    max_new = (smp_r > max_r) ? smp_r : max_r;
    last    = (cnt_r == CNT_W'(WINDOW - 1));
    // A full window holds WINDOW samples, so for WINDOW of two or more this never goes below zero.
    trimmed = sum_add - SUM_W'(min_new) - SUM_W'(max_new);

    primed_nxt = primed_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    emit       = 1'b0;
    raw_now    = 1'b0;

    if (move) begin
      if (!primed_r) begin
        primed_nxt = 1'b1;
        emit       = 1'b1;
        raw_now    = 1'b1;
      end else if (last) begin
        cnt_nxt = '0;
        sum_nxt = '0;
        min_nxt = SAMPLE_MAX;
        max_nxt = '0;
        emit    = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_add;
        min_nxt = min_new;
        max_nxt = max_new;
      end
    end

    if (move) begin
      res_valid_nxt = emit;
    end else if (o_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      primed_r    <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      min_r       <= SAMPLE_MAX;
      max_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        smp_valid_r <= in_valid;
      end
      primed_r    <= primed_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_sample;
    end
    if (emit) begin
      raw_r   <= raw_now;
      value_r <= raw_now ? SUM_W'(smp_r) : trimmed;
    end
  end

  assign o_valid = res_valid_r;
  assign o_raw   = raw_r;
  assign o_value = value_r;

endmodule

`default_nettype wire

// File: hdl/btmf_mean.sv
// Mean stage: divides the trimmed sum by WINDOW-2 (by 1 when WINDOW is at most 2)
// through a reciprocal multiply, saturating at SAMPLE_MAX, or passes the raw first sample. Uses btmf_pkg.
`default_nettype none

module btmf_mean
  import btmf_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   i_valid,
  output logic                                        i_ready,
  input  wire logic                                   i_raw,
  input  wire logic [SAMPLE_W+$clog2(WINDOW)-1:0]     i_value,
  output logic                                        o_valid,
  input  wire logic                                   o_ready,
  output sample_t                                     o_mean
);

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned DIV    = (WINDOW > 2) ? WINDOW - 2 : 1;
  localparam int unsigned DIV_L  = $clog2(DIV);
  localparam int unsigned SHIFT  = SUM_W + DIV_L;
  // ceil(2^(SUM_W+DIV_L) / DIV) gives an exact floor quotient for any
  // dividend below 2^SUM_W.
  localparam longint unsigned MULT =
    ((64'd1 << SHIFT) + longint'(DIV) - 64'd1) / longint'(DIV);
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  localparam int unsigned QUO_W  = PROD_W - SHIFT;
  localparam logic [SUM_W:0] MULT_C = (SUM_W + 1)'(MULT);

  logic              valid_r;
  sample_t           mean_r;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  sample_t           mean_nxt;

  assign i_ready = !valid_r || o_ready;

  always_comb begin
    prod = PROD_W'(i_value) * PROD_W'(MULT_C);
    quo  = prod[PROD_W-1:SHIFT];
    if (i_raw) begin
      mean_nxt = i_value[SAMPLE_W-1:0];
    end else if (quo > QUO_W'(SAMPLE_MAX)) begin
      mean_nxt = SAMPLE_MAX;
    end else begin
      mean_nxt = quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      mean_r <= mean_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_mean  = mean_r;

endmodule

`default_nettype wire

// File: hdl/btmf_volts.sv
// Output stage: scales the mean to battery millivolts and holds the result
// beat until it is taken. Uses btmf_pkg.
`default_nettype none

module btmf_volts
  import btmf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    i_valid,
  output logic         i_ready,
  input  wire sample_t i_mean,
  output logic         o_valid,
  input  wire logic    o_ready,
  output sample_t      o_mean,
  output mv_t          o_mv
);

  localparam int unsigned PROD_W = SAMPLE_W + MV_MULT_W;

  logic              valid_r;
  sample_t           mean_r;
  mv_t               mv_r;
  logic [PROD_W-1:0] prod;

  assign i_ready = !valid_r || o_ready;
  assign prod    = PROD_W'(i_mean) * PROD_W'(MV_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (i_ready) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && i_ready) begin
      mean_r <= i_mean;
      mv_r   <= prod[MV_SHIFT +: MV_W];
    end
  end

  assign o_valid = valid_r;
  assign o_mean  = mean_r;
  assign o_mv    = mv_r;

endmodule

`default_nettype wire

// File: hdl/battery_trimmed_mean_filter.sv
// Battery trimmed mean filter: one sample a cycle in, one result per window.
// A result passes through the input register, window register, mean register
// and output register after the beat of the sample that causes it.
// Throughput: one sample per cycle, held back only by a stalled output.
// Reset (synchronous, active low) empties the pipeline and clears the window;
// the first sample after reset is passed through as its own result.
`default_nettype none

module battery_trimmed_mean_filter
  import btmf_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  btmf_in_if.sink     in_bus,
  btmf_out_if.source  out_bus
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);

  logic             win_valid;
  logic             win_ready;
  logic             win_raw;
  logic [SUM_W-1:0] win_value;
  logic             mean_valid;
  logic             mean_ready;
  sample_t          mean_val;

  btmf_window #(.WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_sample (in_bus.adc_sample),
    .o_valid   (win_valid),
    .o_ready   (win_ready),
    .o_raw     (win_raw),
    .o_value   (win_value)
  );

  btmf_mean #(.WINDOW(WINDOW)) u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (win_valid),
    .i_ready (win_ready),
    .i_raw   (win_raw),
    .i_value (win_value),
    .o_valid (mean_valid),
    .o_ready (mean_ready),
    .o_mean  (mean_val)
  );

  btmf_volts u_volts (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (mean_valid),
    .i_ready (mean_ready),
    .i_mean  (mean_val),
    .o_valid (out_bus.valid),
    .o_ready (out_bus.ready),
    .o_mean  (out_bus.mean_sample),
    .o_mv    (out_bus.battery_millivolts)
  );

endmodule

`default_nettype wire

// File: test/tb_battery_trimmed_mean_filter.sv
// Self-checking testbench for battery_trimmed_mean_filter: random sample streams,
// random source gaps and sink stalls, every result checked against a local model.
// Depends on btmf_pkg and the channel interfaces in btmf_ifs.

module tb_battery_trimmed_mean_filter
  import btmf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW      = WINDOW_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    sample_t mean_sample;
    mv_t     battery_millivolts;
  } voltage_reading_t;

  logic clk = 1'b0;
  logic rst_n;

  btmf_in_if  in_ch ();
  btmf_out_if out_ch ();

  battery_trimmed_mean_filter #(.WINDOW(WINDOW)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t          adc_stream[$];
  voltage_reading_t expected_readings[$];

  // Local copy of the filter state.
  logic        primed;
  logic [6:0]  win_count;
  logic [17:0] win_sum;
  sample_t     win_min;
  sample_t     win_max;

  logic        sample_beat = 1'b0;
  logic        reading_beat = 1'b0;
  logic        calm = 1'b0;
  int unsigned send_gap;
  int unsigned hold_off;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned mismatches = 0;

  // Quiet stretches with no idling at all alternate with random idling.
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void push_reading(sample_t avg);
    voltage_reading_t r;
    longint unsigned scaled;
    scaled = 64'(avg);
    scaled = (scaled * MV_NUM) / MV_DEN;
    r.mean_sample = avg;
    r.battery_millivolts = mv_t'(scaled);
    expected_readings.push_back(r);
  endfunction

  function automatic void filter_sample(sample_t s);
    logic [17:0] trimmed;
    int unsigned avg;
    if (!primed) begin
      primed = 1'b1;
      push_reading(s);
      return;
    end
    win_sum = win_sum + s;
    if (s < win_min) win_min = s;
    if (s > win_max) win_max = s;
    win_count = win_count + 7'd1;
    if (win_count < WINDOW) return;
    // One copy of the smallest and one of the largest sample are dropped.
    trimmed = win_sum;
    trimmed = (trimmed >= win_min) ? trimmed - win_min : '0;
    trimmed = (trimmed >= win_max) ? trimmed - win_max : '0;
    avg = trimmed / (WINDOW - 2);
    if (avg > SAMPLE_MAX) avg = 32'(SAMPLE_MAX);
    win_count = '0;
    win_sum = '0;
    win_min = SAMPLE_MAX;
    win_max = '0;
    push_reading(sample_t'(avg));
  endfunction

  // Builds one window's worth of samples in one of several shapes.
  function automatic void add_random_window();
    int unsigned shape;
    int unsigned base;
    int unsigned lo_pos;
    int unsigned hi_pos;
    int unsigned v;
    shape = $urandom_range(0, 7);
    base = $urandom_range(0, SAMPLE_MAX);
    lo_pos = $urandom_range(0, WINDOW - 1);
    hi_pos = $urandom_range(0, WINDOW - 1);
    if (shape == 1) begin
      case ($urandom_range(0, 2))
        0: base = 0;
        1: base = 32'(SAMPLE_MAX);
        default: ;
      endcase
    end
    for (int unsigned i = 0; i < WINDOW; i++) begin
      case (shape)
        1: v = base;
        2: begin
          v = base + $urandom_range(0, 7);
          if (v > SAMPLE_MAX) v = 32'(SAMPLE_MAX);
        end
        3: begin
          case ($urandom_range(0, 2))
            0: v = 0;
            1: v = 32'(SAMPLE_MAX);
            default: v = $urandom_range(0, SAMPLE_MAX);
          endcase
        end
        4: begin
          v = base;
          if (i == lo_pos) v = 0;
          else if (i == hi_pos) v = 32'(SAMPLE_MAX);
        end
        default: v = $urandom_range(0, SAMPLE_MAX);
      endcase
      adc_stream.push_back(sample_t'(v));
    end
  endfunction

  // Monitor: takes the expectation at each sample beat and checks each result beat.
  always @(posedge clk) begin
    voltage_reading_t want;
    cycle_count++;
    sample_beat = rst_n && in_ch.valid && in_ch.ready;
    reading_beat = rst_n && out_ch.valid && out_ch.ready;
    if (reading_beat) begin
      readings_checked++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result mean_sample=%0d battery_millivolts=%0d",
                 $time, out_ch.mean_sample, out_ch.battery_millivolts);
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.mean_sample !== want.mean_sample) begin
          mismatches++;
          $display("%0t: mean_sample expected %0d, got %0d",
                   $time, want.mean_sample, out_ch.mean_sample);
        end
        if (out_ch.battery_millivolts !== want.battery_millivolts) begin
          mismatches++;
          $display("%0t: battery_millivolts expected %0d, got %0d",
                   $time, want.battery_millivolts, out_ch.battery_millivolts);
        end
      end
    end
    if (sample_beat) begin
      samples_sent++;
      filter_sample(in_ch.adc_sample);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_readings.size());
      $display("tb_battery_trimmed_mean_filter: FAIL");
      $finish;
    end
  end

  // Source driver: presents the next sample after its drawn gap.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || sample_beat)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (adc_stream.size() > 0) begin
        in_ch.adc_sample <= adc_stream.pop_front();
        in_ch.valid <= 1'b1;
        send_gap = draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink driver: stalls for a drawn number of cycles after every result beat.
  always @(negedge clk) begin
    if (rst_n) begin
      if (reading_beat) hold_off = draw_gap();
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    primed = 1'b0;
    win_count = '0;
    win_sum = '0;
    win_min = SAMPLE_MAX;
    win_max = '0;
    send_gap = draw_gap();
    hold_off = draw_gap();

    // The first sample passes straight through; use the top of the range.
    adc_stream.push_back(SAMPLE_MAX);
    // A window of full-scale samples gives the largest voltage.
    for (int unsigned i = 0; i < WINDOW; i++) adc_stream.push_back(SAMPLE_MAX);
    // Ties at both ends: only one copy of each extreme may be dropped.
    for (int unsigned i = 0; i < WINDOW; i++) begin
      case (i % 5)
        0: adc_stream.push_back('0);
        1: adc_stream.push_back(SAMPLE_MAX);
        2: adc_stream.push_back(sample_t'(1));
        3: adc_stream.push_back(sample_t'(SAMPLE_MAX - 1));
        default: adc_stream.push_back(sample_t'(2048 + i));
      endcase
    end

    while (adc_stream.size() < 1 + 2 * WINDOW + RANDOM_ITEMS) begin
      // Now and then a short run of loose samples shifts the window phase.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, WINDOW - 1))
          adc_stream.push_back(sample_t'($urandom_range(0, SAMPLE_MAX)));
      end else begin
        add_random_window();
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (adc_stream.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ADC samples through %0d-sample windows with random gaps and stalls.",
             samples_sent, WINDOW);
    $display("Checked %0d voltage results, %0d field mismatches.",
             readings_checked, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_battery_trimmed_mean_filter: PASS");
    end else begin
      $display("tb_battery_trimmed_mean_filter: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/btmf_pkg.sv
hdl/btmf_ifs.sv
hdl/btmf_window.sv
hdl/btmf_mean.sv
hdl/btmf_volts.sv
hdl/battery_trimmed_mean_filter.sv
test/tb_battery_trimmed_mean_filter.sv
